### hdl/pdws_pkg.sv
// Package for the palette DAC write sequencer.
// Holds the shared widths, codes and the stage-to-stage beat types.
// No dependencies.
package pdws_pkg;

  // Default palette size.
  localparam int PALETTE_ENTRIES_DEF = 256;

  // Pointer holds 0 .. 256, where the palette size means past the end.
  localparam int PTR_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int COMP_W  = 2;

  // Port codes carried in the kind field.
  localparam logic KIND_INDEX = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Color component codes.
  localparam logic [COMP_W-1:0] COMP_RED   = 2'd0;
  localparam logic [COMP_W-1:0] COMP_GREEN = 2'd1;
  localparam logic [COMP_W-1:0] COMP_BLUE  = 2'd2;

  // One port write as held in the input register.
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] port_byte;
  } pdws_item_t;

  // One palette write result.
  typedef struct packed {
    logic [BYTE_W-1:0] entry;
    logic [COMP_W-1:0] component;
    logic [BYTE_W-1:0] color_value;
    logic              palette_complete;
  } pdws_result_t;

  // Forward valid between two internal stages.
  typedef struct packed {
    logic valid;
  } pdws_hs_t;

endpackage

### hdl/palette_dac_write_sequencer_core.sv
// Top level of the palette DAC write sequencer.
// Depends on pdws_pkg, pdws_in_stage, pdws_sequencer and pdws_out_stage.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   input   | in_valid / in_ready | kind, port_byte
//   output  | out_valid/out_ready | entry, component, color_value,
//           |                     | palette_complete
//
// One beat is accepted per cycle while no stall holds the input register; a data
// beat's result is then loaded into the result register and can leave from there.
// Index beats and data beats past the palette end give no result.
// Reset puts the pointer at entry 0, red, and empties both registers.
// A stalled output holds its beat while the input register keeps one more.
module palette_dac_write_sequencer_core #(
  parameter int PALETTE_ENTRIES = pdws_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [pdws_pkg::BYTE_W-1:0]   port_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pdws_pkg::BYTE_W-1:0]   entry,
  output logic [pdws_pkg::COMP_W-1:0]   component,
  output logic [pdws_pkg::BYTE_W-1:0]   color_value,
  output logic                          palette_complete
);

  pdws_pkg::pdws_item_t   in_item;
  pdws_pkg::pdws_item_t   item;
  pdws_pkg::pdws_result_t res;
  pdws_pkg::pdws_result_t out_res;
  pdws_pkg::pdws_hs_t     res_hs;
  logic                   item_valid;
  logic                   item_take;
  logic                   res_ready;

  assign in_item.kind      = kind;
  assign in_item.port_byte = port_byte;

  // Input register.
  pdws_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  // Pointer and component logic.
  pdws_sequencer #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item),
    .res_hs_out (res_hs),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Result register.
  pdws_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_hs    (res_hs),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign entry            = out_res.entry;
  assign component        = out_res.component;
  assign color_value      = out_res.color_value;
  assign palette_complete = out_res.palette_complete;

endmodule

### hdl/pdws_in_stage.sv
// Input register stage of the palette DAC write sequencer.
// Depends on pdws_pkg for the item type.
module pdws_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pdws_pkg::pdws_item_t in_item,
  output logic                item_valid,
  input  logic                item_take,
  output pdws_pkg::pdws_item_t item
);

  logic held;

  // A new beat enters when the register is empty or is being drained.
  assign in_ready   = !held || item_take;
  assign item_valid = held;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

### hdl/pdws_sequencer.sv
// Pointer and component sequencing for the palette DAC write path.
// Depends on pdws_pkg for the item, result and handshake types.
module pdws_sequencer #(
  parameter int PALETTE_ENTRIES = pdws_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_take,
  input  pdws_pkg::pdws_item_t  item,
  output pdws_pkg::pdws_hs_t    res_hs_out,
  input  logic                  res_ready,
  output pdws_pkg::pdws_result_t res
);

  localparam logic [pdws_pkg::PTR_W-1:0] ENTRIES_P = pdws_pkg::PTR_W'(PALETTE_ENTRIES);
  localparam logic [pdws_pkg::PTR_W-1:0] LAST_P    = pdws_pkg::PTR_W'(PALETTE_ENTRIES - 1);

  logic [pdws_pkg::PTR_W-1:0]  entry_pointer;
  logic [pdws_pkg::PTR_W-1:0]  entry_pointer_next;
  logic [pdws_pkg::COMP_W-1:0] component_counter;
  logic [pdws_pkg::COMP_W-1:0] component_counter_next;
  logic [pdws_pkg::COMP_W-1:0] comp;
  logic                        has_result;
  logic                        is_blue;

  // A data write inside the palette yields a result; anything else is absorbed.
  assign has_result = (item.kind == pdws_pkg::KIND_DATA) && (entry_pointer < ENTRIES_P);
  assign item_take  = item_valid && (!has_result || res_ready);

  assign res_hs_out.valid = item_valid && has_result;

  // Clamp a stray counter value to blue, then form the result.
  assign comp    = (component_counter > pdws_pkg::COMP_BLUE) ? pdws_pkg::COMP_BLUE
                                                             : component_counter;
  assign is_blue = (comp == pdws_pkg::COMP_BLUE);

  assign res.entry            = entry_pointer[pdws_pkg::BYTE_W-1:0];
  assign res.component        = comp;
  assign res.color_value      = {item.port_byte[pdws_pkg::BYTE_W-3:0], 2'b00};
  assign res.palette_complete = is_blue && (entry_pointer == LAST_P);

  // Next pointer and component for the beat being taken.
  always_comb begin
    entry_pointer_next     = entry_pointer;
    component_counter_next = component_counter;
    if (item.kind == pdws_pkg::KIND_INDEX) begin
      entry_pointer_next     = {1'b0, item.port_byte};
      component_counter_next = pdws_pkg::COMP_RED;
    end else if (has_result) begin
      if (is_blue) begin
        component_counter_next = pdws_pkg::COMP_RED;
        entry_pointer_next     = entry_pointer + pdws_pkg::PTR_W'(1);
      end else begin
        component_counter_next = comp + pdws_pkg::COMP_W'(1);
      end
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_pointer     <= '0;
      component_counter <= pdws_pkg::COMP_RED;
    end else if (item_take) begin
      entry_pointer     <= entry_pointer_next;
      component_counter <= component_counter_next;
    end
  end

endmodule

### hdl/pdws_out_stage.sv
// Result register stage of the palette DAC write sequencer.
// Depends on pdws_pkg for the result and handshake types.
module pdws_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  pdws_pkg::pdws_hs_t     res_hs,
  output logic                   res_ready,
  input  pdws_pkg::pdws_result_t res,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pdws_pkg::pdws_result_t out_res
);

  logic held;

  // Load when empty or when the held beat leaves in this cycle.
  assign res_ready = !held || out_ready;
  assign out_valid = held;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (res_ready) begin
      held <= res_hs.valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (res_hs.valid && res_ready) begin
      out_res <= res;
    end
  end

endmodule

### hdl/pdws_checker.sv
// Port-level checks for the palette DAC write sequencer.
// Depends on pdws_pkg; bound to palette_dac_write_sequencer_core below.
module pdws_checker #(
  parameter int PALETTE_ENTRIES = pdws_pkg::PALETTE_ENTRIES_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pdws_pkg::BYTE_W-1:0] entry,
  input logic [pdws_pkg::COMP_W-1:0] component,
  input logic [pdws_pkg::BYTE_W-1:0] color_value,
  input logic                        palette_complete
);

  localparam logic [pdws_pkg::BYTE_W-1:0] LAST_ENTRY = pdws_pkg::BYTE_W'(PALETTE_ENTRIES - 1);

  // A stalled result beat holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry) && $stable(component)
      && $stable(color_value) && $stable(palette_complete))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // Only red, green or blue is ever reported.
  a_comp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> component == pdws_pkg::COMP_RED || component == pdws_pkg::COMP_GREEN
      || component == pdws_pkg::COMP_BLUE)
    else $error("bad component code");

  // Completion comes only with blue of the last entry.
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && palette_complete |-> component == pdws_pkg::COMP_BLUE
      && entry == LAST_ENTRY)
    else $error("palette complete on wrong entry or component");

  // The color value always has its two low bits clear.
  a_shift: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> color_value[1:0] == 2'b00)
    else $error("color value not shifted");

endmodule

bind palette_dac_write_sequencer_core pdws_checker #(
  .PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_pdws_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .entry            (entry),
  .component        (component),
  .color_value      (color_value),
  .palette_complete (palette_complete)
);
